@@ src/rpn_pkg.sv @@
`timescale 1ns / 1ps

package rpn_pkg;

	// Stack geometry.
	localparam int STACK_DEPTH = 8;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// Word widths.
	localparam int DATA_W   = 32;
	localparam int MODE_W   = 4;
	localparam int STATUS_W = 3;

	// Token codes carried on the input tuser.
	localparam logic [MODE_W-1:0] MODE_PUSH = 4'd0;
	localparam logic [MODE_W-1:0] MODE_ADD  = 4'd1;
	localparam logic [MODE_W-1:0] MODE_SUB  = 4'd2;
	localparam logic [MODE_W-1:0] MODE_MUL  = 4'd3;
	localparam logic [MODE_W-1:0] MODE_DIV  = 4'd4;
	localparam logic [MODE_W-1:0] MODE_MOD  = 4'd5;
	localparam logic [MODE_W-1:0] MODE_INC  = 4'd6;
	localparam logic [MODE_W-1:0] MODE_DEC  = 4'd7;
	localparam logic [MODE_W-1:0] MODE_END  = 4'd8;
	localparam logic [MODE_W-1:0] MODE_CONT = 4'd9;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BADFINAL  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd4;

	// Divider response toward the sequencer.
	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
		logic [DATA_W-1:0] remainder;
	} div_rsp_t;

endpackage

@@ src/rpn_stack_evaluator_top.sv @@
`timescale 1ns / 1ps

// Postfix integer expression evaluator on an eight-entry stack of 32-bit words.
// Input channel (s_*): one word per token; s_tuser carries the token code and
// s_tdata the value for a push. Output channel (m_*): one word per finished
// expression or per error; m_tdata is the value (zero on error), m_tuser holds
// the status code and the continue flag.
// Each token is accepted while the stack memory reads the two top entries,
// then executed. Multiply adds a write-back step (S_WB), and divide or modulo
// runs the shared bit-serial divider (S_DIV) and writes the result back when
// the divider finishes. One token is in flight at a time.
// A result waits in the output register; further tokens that produce no result
// are still taken. When a token needs to emit while that register is full,
// execution holds until the receiver takes the waiting word.
// Reset empties the stack at once (only the depth counter is cleared) and
// leaves no result pending; no clearing pass is needed.
module rpn_stack_evaluator_top
	import rpn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] operand
	input  logic [3:0]  s_tuser,   // [3:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] value
	output logic [3:0]  m_tuser    // [2:0] status, [3] ended_by_continue
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WB,
		S_DIV
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    depth_q;
	logic [MODE_W-1:0]   mode_s1;
	logic [DATA_W-1:0]   operand_s1;
	logic [DATA_W-1:0]   res_q;
	logic                out_valid_q;
	logic [DATA_W-1:0]   out_value_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_cont_q;

	logic [CNT_W-1:0]    depth_m1;
	logic [CNT_W-1:0]    depth_m2;
	logic [ADDR_W-1:0]   top_addr;
	logic [ADDR_W-1:0]   second_addr;
	logic [ADDR_W-1:0]   push_addr;
	logic [DATA_W-1:0]   val_a;
	logic [DATA_W-1:0]   val_b;
	logic [DATA_W-1:0]   product;
	logic                out_free;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [DATA_W-1:0]   ram_wdata;
	logic                div_start;
	div_rsp_t            div_rsp;

	logic                emit;
	logic [DATA_W-1:0]   emit_value;
	logic [STATUS_W-1:0] emit_status;
	logic                emit_cont;
	logic [CNT_W-1:0]    depth_nxt;
	state_t              state_nxt;
	logic                mul_load;

	// Stack addresses follow the current depth.
	assign depth_m1    = depth_q - CNT_W'(1);
	assign depth_m2    = depth_q - CNT_W'(2);
	assign top_addr    = depth_m1[ADDR_W-1:0];
	assign second_addr = depth_m2[ADDR_W-1:0];
	assign push_addr   = depth_q[ADDR_W-1:0];

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign product  = val_a * val_b;

	// Stack memory: reads the two top entries while waiting for a token.
	rpn_stack_ram u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (state_q == S_IDLE),
		.raddr_a (second_addr),
		.raddr_b (top_addr),
		.rdata_a (val_a),
		.rdata_b (val_b)
	);

	// Shared iterative divider for divide and modulo.
	rpn_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (val_a),
		.divisor  (val_b),
		.rsp      (div_rsp)
	);

	// Token execution: memory writes, depth update and result generation.
	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = second_addr;
		ram_wdata   = res_q;
		div_start   = 1'b0;
		mul_load    = 1'b0;
		emit        = 1'b0;
		emit_value  = '0;
		emit_status = ST_OK;
		emit_cont   = 1'b0;
		depth_nxt   = depth_q;
		state_nxt   = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt = S_IDLE;
				case (mode_s1)
					MODE_PUSH: begin
						if (depth_q == CNT_W'(STACK_DEPTH)) begin
							emit        = 1'b1;
							emit_status = ST_OVERFLOW;
							depth_nxt   = '0;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = push_addr;
							ram_wdata = operand_s1;
							depth_nxt = depth_q + CNT_W'(1);
						end
					end
					MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD: begin
						if (depth_q < CNT_W'(2)) begin
							emit        = 1'b1;
							emit_status = ST_UNDERFLOW;
							depth_nxt   = '0;
						end else if ((mode_s1 == MODE_DIV || mode_s1 == MODE_MOD)
								&& val_b == '0) begin
							emit        = 1'b1;
							emit_status = ST_DIVZERO;
							depth_nxt   = '0;
						end else if (mode_s1 == MODE_MUL) begin
							mul_load  = 1'b1;
							state_nxt = S_WB;
						end else if (mode_s1 == MODE_DIV || mode_s1 == MODE_MOD) begin
							div_start = 1'b1;
							state_nxt = S_DIV;
						end else begin
							ram_we    = 1'b1;
							ram_wdata = (mode_s1 == MODE_ADD) ? (val_a + val_b)
							                                  : (val_a - val_b);
							depth_nxt = depth_m1;
						end
					end
					MODE_INC, MODE_DEC: begin
						if (depth_q == '0) begin
							emit        = 1'b1;
							emit_status = ST_UNDERFLOW;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = top_addr;
							ram_wdata = (mode_s1 == MODE_INC) ? (val_b + DATA_W'(1))
							                                  : (val_b - DATA_W'(1));
						end
					end
					MODE_END, MODE_CONT: begin
						emit      = 1'b1;
						depth_nxt = '0;
						if (depth_q == '0) begin
							emit_status = ST_BADFINAL;
						end else begin
							emit_value = val_b;
							emit_cont  = (mode_s1 == MODE_CONT);
						end
					end
					default: begin
					end
				endcase
				// Hold the whole token while the output word is still unread.
				if (emit && !out_free) begin
					emit      = 1'b0;
					ram_we    = 1'b0;
					depth_nxt = depth_q;
					state_nxt = S_EXEC;
				end
			end
			S_WB: begin
				ram_we    = 1'b1;
				depth_nxt = depth_m1;
				state_nxt = S_IDLE;
			end
			S_DIV: begin
				if (div_rsp.done) begin
					ram_we    = 1'b1;
					ram_wdata = (mode_s1 == MODE_MOD) ? div_rsp.remainder
					                                  : div_rsp.quotient;
					depth_nxt = depth_m1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Sequencer state, depth counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			depth_q <= depth_nxt;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Token capture, product register and output word.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1    <= s_tuser;
			operand_s1 <= s_tdata;
		end
		if (mul_load) begin
			res_q <= product;
		end
		if (emit) begin
			out_value_q  <= emit_value;
			out_status_q <= emit_status;
			out_cont_q   <= emit_cont;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = {out_cont_q, out_status_q};

	// The depth counter never passes the stack size.
	assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= CNT_W'(STACK_DEPTH))
		else $error("stack depth out of range");

	// An error result always carries a zero value and no continue flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2:0] != ST_OK) |-> (m_tdata == '0 && !m_tuser[3]))
		else $error("error result with nonzero payload");

	// The memory is never written while a token is being accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_we)
		else $error("stack write outside execution");

	// The divider only finishes while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV))
		else $error("divider finished outside divide wait");

	// A multiply product is always written back in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_load |=> (state_q == S_WB && ram_we))
		else $error("multiply result not written back");

endmodule

@@ src/rpn_stack_ram.sv @@
`timescale 1ns / 1ps

module rpn_stack_ram
	import rpn_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [DATA_W-1:0] rdata_a,
	output logic [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0] mem [STACK_DEPTH];

	// One write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Two registered read ports; the data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

@@ src/rpn_divider.sv @@
`timescale 1ns / 1ps

module rpn_divider
	import rpn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output div_rsp_t          rsp
);

	localparam int STEP_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] den_q;
	logic              neg_q_q;
	logic              neg_r_q;

	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   trial;
	logic [DATA_W-1:0] mag_a;
	logic [DATA_W-1:0] mag_b;

	// Operand magnitudes; the most negative value maps onto itself as unsigned.
	assign mag_a = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
	assign mag_b = divisor[DATA_W-1]  ? (~divisor + DATA_W'(1))  : divisor;

	// One restoring step: shift in the next dividend bit and try to subtract.
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign trial   = shifted - {1'b0, den_q};

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= '0;
			quo_q   <= mag_a;
			den_q   <= mag_b;
			neg_q_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			neg_r_q <= dividend[DATA_W-1];
		end else if (busy_q) begin
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
			end else begin
				rem_q <= shifted[DATA_W-1:0];
			end
			quo_q <= {quo_q[DATA_W-2:0], ~trial[DATA_W]};
		end
	end

	// Sign correction: quotient truncates toward zero, remainder takes the dividend's sign.
	assign rsp.done      = done_q;
	assign rsp.quotient  = neg_q_q ? (~quo_q + DATA_W'(1)) : quo_q;
	assign rsp.remainder = neg_r_q ? (~rem_q + DATA_W'(1)) : rem_q;

endmodule

@@ sim/tb_rpn_stack_evaluator_top.sv @@
`timescale 1ns / 1ps

module tb_rpn_stack_evaluator_top;
	import rpn_pkg::*;

	// Token codes above continue carry no meaning and are dropped by the block.
	localparam logic [MODE_W-1:0] MODE_RESERVED_LO = 4'd10;
	localparam logic [MODE_W-1:0] MODE_RESERVED_HI = 4'd15;

	localparam int TOKEN_TARGET = 1500;
	localparam int RUN_LIMIT    = 500000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [DATA_W-1:0]   value;
		logic [STATUS_W-1:0] status;
		logic                by_cont;
	} calc_result_t;

	// One opening token; known rows carry a result typed in by hand.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [DATA_W-1:0] operand;
		logic              known;
		calc_result_t      want;
	} token_row_t;

	localparam calc_result_t NO_RESULT = '0;

	localparam token_row_t OPENING_TOKENS [32] = '{
		'{MODE_END,         32'h0000_0000, 1'b1, '{32'h0, ST_BADFINAL, 1'b0}},
		'{MODE_DEC,         32'hffff_ffff, 1'b1, '{32'h0, ST_UNDERFLOW, 1'b0}},
		'{MODE_PUSH,        32'h7fff_ffff, 1'b0, NO_RESULT},
		'{MODE_SUB,         32'h0000_0000, 1'b1, '{32'h0, ST_UNDERFLOW, 1'b0}},
		'{MODE_PUSH,        32'h8000_0000, 1'b0, NO_RESULT},
		'{MODE_PUSH,        32'hffff_ffff, 1'b0, NO_RESULT},
		'{MODE_DIV,         32'h1234_5678, 1'b0, NO_RESULT},
		'{MODE_END,         32'h0000_0000, 1'b1, '{32'h8000_0000, ST_OK, 1'b0}},
		'{MODE_PUSH,        32'h8000_0000, 1'b0, NO_RESULT},
		'{MODE_PUSH,        32'hffff_ffff, 1'b0, NO_RESULT},
		'{MODE_MOD,         32'h0000_0000, 1'b0, NO_RESULT},
		'{MODE_INC,         32'h0000_0000, 1'b0, NO_RESULT},
		'{MODE_PUSH,        32'h7fff_ffff, 1'b0, NO_RESULT},
		'{MODE_ADD,         32'hffff_ffff, 1'b0, NO_RESULT},
		'{MODE_PUSH,        32'h0000_0003, 1'b0, NO_RESULT},
		'{MODE_MUL,         32'h0000_0000, 1'b0, NO_RESULT},
		'{MODE_DEC,         32'h0000_0000, 1'b0, NO_RESULT},
		'{MODE_PUSH,        32'h0000_0000, 1'b0, NO_RESULT},
		'{MODE_CONT,        32'h0000_0000, 1'b1, '{32'h0, ST_OK, 1'b1}},
		'{MODE_RESERVED_HI, 32'hffff_ffff, 1'b0, NO_RESULT},
		'{MODE_PUSH,        32'h0000_0001, 1'b0, NO_RESULT},
		'{MODE_PUSH,        32'hffff_ffff, 1'b0, NO_RESULT},
		'{MODE_PUSH,        32'h5555_5555, 1'b0, NO_RESULT},
		'{MODE_PUSH,        32'haaaa_aaaa, 1'b0, NO_RESULT},
		'{MODE_PUSH,        32'h8000_0000, 1'b0, NO_RESULT},
		'{MODE_PUSH,        32'h7fff_ffff, 1'b0, NO_RESULT},
		'{MODE_PUSH,        32'h1234_5678, 1'b0, NO_RESULT},
		'{MODE_PUSH,        32'h0000_0000, 1'b0, NO_RESULT},
		'{MODE_PUSH,        32'h0000_0005, 1'b1, '{32'h0, ST_OVERFLOW, 1'b0}},
		'{MODE_PUSH,        32'h0000_0009, 1'b0, NO_RESULT},
		'{MODE_PUSH,        32'h0000_0000, 1'b0, NO_RESULT},
		'{MODE_MOD,         32'h0000_0000, 1'b1, '{32'h0, ST_DIVZERO, 1'b0}}
	};

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [31:0]       s_tdata  = '0;
	logic [3:0]        s_tuser  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [31:0]       m_tdata;
	logic [3:0]        m_tuser;

	// Shadow copy of the evaluation stack.
	logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
	int                calc_depth = 0;

	calc_result_t      expected_results [$];
	int                token_count    = 0;
	int                mismatch_count = 0;
	int                cycle_count    = 0;
	bit                tx_idle_en     = 1'b1;
	bit                rx_idle_en     = 1'b1;

	rpn_stack_evaluator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Applies one token to the shadow stack; returns 1 when it yields a result word.
	function automatic bit eval_token(input logic [MODE_W-1:0] mode,
			input logic [DATA_W-1:0] operand, output calc_result_t res);
		logic [DATA_W-1:0]   lhs;
		logic [DATA_W-1:0]   rhs;
		logic [DATA_W-1:0]   acc;
		logic [STATUS_W-1:0] err;
		res = '0;
		err = ST_OK;
		case (mode)
			MODE_PUSH: begin
				if (calc_depth >= STACK_DEPTH) begin
					err = ST_OVERFLOW;
				end else begin
					calc_stack[calc_depth] = operand;
					calc_depth++;
				end
			end
			MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD: begin
				if (calc_depth < 2) begin
					err = ST_UNDERFLOW;
				end else begin
					lhs = calc_stack[calc_depth - 2];
					rhs = calc_stack[calc_depth - 1];
					if ((mode == MODE_DIV || mode == MODE_MOD) && rhs == '0) begin
						err = ST_DIVZERO;
					end else begin
						case (mode)
							MODE_ADD: acc = lhs + rhs;
							MODE_SUB: acc = lhs - rhs;
							MODE_MUL: acc = lhs * rhs;
							default: begin
								// The most negative value over minus one wraps.
								if (lhs == 32'h8000_0000 && rhs == 32'hffff_ffff) begin
									acc = (mode == MODE_DIV) ? lhs : '0;
								end else if (mode == MODE_DIV) begin
									acc = $signed(lhs) / $signed(rhs);
								end else begin
									acc = $signed(lhs) % $signed(rhs);
								end
							end
						endcase
						calc_stack[calc_depth - 2] = acc;
						calc_depth--;
					end
				end
			end
			MODE_INC, MODE_DEC: begin
				if (calc_depth < 1) begin
					err = ST_UNDERFLOW;
				end else begin
					calc_stack[calc_depth - 1] += (mode == MODE_INC) ? 32'h1 : 32'hffff_ffff;
				end
			end
			MODE_END, MODE_CONT: begin
				if (calc_depth < 1) begin
					err = ST_BADFINAL;
				end else begin
					res.value   = calc_stack[calc_depth - 1];
					res.status  = ST_OK;
					res.by_cont = (mode == MODE_CONT);
					calc_depth  = 0;
					return 1'b1;
				end
			end
			default: ;
		endcase
		if (err != ST_OK) begin
			calc_depth = 0;
			res.status = err;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Operands lean on the extremes and on small values, zero among them.
	function automatic logic [DATA_W-1:0] pick_operand();
		case ($urandom_range(0, 6))
			0, 1: return DATA_W'($signed($urandom_range(0, 6)) - 3);
			2:    return 32'h8000_0000;
			3:    return 32'h7fff_ffff;
			4:    return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < 40)
			$display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Sends one word and records its expected result at the accepting edge.
	task automatic issue_token(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] operand,
			input logic known, input calc_result_t want);
		calc_result_t predicted;
		bit           has_result;
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= operand;
		do @(posedge clk); while (!s_tready);
		has_result = eval_token(mode, operand, predicted);
		if (known)
			expected_results.push_back(want);
		else if (has_result)
			expected_results.push_back(predicted);
		if (mode < MODE_RESERVED_LO)
			token_count++;
	endtask

	task automatic feed(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] operand);
		issue_token(mode, operand, 1'b0, NO_RESULT);
	endtask

	task automatic wait_results_drained();
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// A well-formed expression with random content, closed by end or continue.
	task automatic feed_expression();
		int depth;
		int length;
		int pick;
		depth  = 0;
		length = $urandom_range(1, 14);
		for (int i = 0; i < length; i++) begin
			pick = $urandom_range(0, 9);
			if (depth == 0 || (pick < 4 && depth < STACK_DEPTH)) begin
				feed(MODE_PUSH, pick_operand());
				depth++;
			end else if (pick < 8 && depth >= 2) begin
				feed(MODE_W'($urandom_range(MODE_ADD, MODE_MOD)), $urandom);
				depth--;
			end else begin
				feed($urandom_range(0, 1) ? MODE_INC : MODE_DEC, $urandom);
			end
		end
		feed($urandom_range(0, 1) ? MODE_CONT : MODE_END, $urandom);
	endtask

	// Broken sequences: too many pushes, or at most one push; either way one random token from add to continue follows.
	task automatic feed_broken();
		int pushes;
		if ($urandom_range(0, 1)) begin
			pushes = STACK_DEPTH + 1;
		end else begin
			pushes = $urandom_range(0, 1);
		end
		for (int i = 0; i < pushes; i++)
			feed(MODE_PUSH, pick_operand());
		feed(MODE_W'($urandom_range(MODE_ADD, MODE_CONT)), $urandom);
	endtask

	// Stimulus: reset, the opening table, then random expressions, broken sequences and token bursts.
	initial begin : stimulus
		bit drained_once;
		drained_once = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING_TOKENS[i])
			issue_token(OPENING_TOKENS[i].mode, OPENING_TOKENS[i].operand,
				OPENING_TOKENS[i].known, OPENING_TOKENS[i].want);

		while (token_count < TOKEN_TARGET) begin
			// Quiet stretches with no idling, and none at all near the end.
			tx_idle_en = !((token_count >= 500 && token_count < 600) ||
				token_count >= TOKEN_TARGET - 150);
			rx_idle_en = tx_idle_en;
			if (!drained_once && token_count >= 700) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				wait_results_drained();
				drained_once = 1'b1;
			end
			case ($urandom_range(0, 9))
				0: begin
					repeat ($urandom_range(1, 6))
						feed(MODE_W'($urandom_range(0, 15)), $urandom);
				end
				1: feed_broken();
				default: feed_expression();
			endcase
		end
		s_tvalid <= 1'b0;

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Receiver pacing: random stall bursts while enabled.
	initial begin : sink_pacing
		while (!arst_n) @(posedge clk);
		forever begin
			if (rx_idle_en && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Compare each accepted output word with the oldest expectation.
	always @(posedge clk) begin : result_check
		calc_result_t oldest;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result word with none expected", m_tdata, '0);
			end else begin
				oldest = expected_results.pop_front();
				if (m_tdata !== oldest.value)
					report_mismatch("value", m_tdata, oldest.value);
				if (m_tuser[2:0] !== oldest.status)
					report_mismatch("status", 32'(m_tuser[2:0]), 32'(oldest.status));
				if (m_tuser[3] !== oldest.by_cont)
					report_mismatch("continue flag", 32'(m_tuser[3]), 32'(oldest.by_cont));
			end
		end
	end

	// Watchdog on the total run length.
	initial begin : watchdog
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, expected_results.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
src/rpn_pkg.sv
src/rpn_stack_ram.sv
src/rpn_divider.sv
src/rpn_stack_evaluator_top.sv
sim/tb_rpn_stack_evaluator_top.sv
